@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock out of reset
`define IPT_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define IPT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ipt_pkg.sv @@
package ipt_pkg;

    localparam int FRAMES      = 128;
    localparam int PAGE_BITS   = 20;
    localparam int IDX_W       = $clog2(FRAMES);
    localparam int FRAME_IN_W  = 8;
    localparam int FOUND_W     = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_FAULT    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed
    {
        opcode_t                 opcode;
        logic [PAGE_BITS-1:0]    page;
        logic [FRAME_IN_W-1:0]   frame;
    } req_t;

    typedef struct packed
    {
        status_t                 status;
        logic [FOUND_W-1:0]      found_frame;
    } res_t;

    typedef struct packed
    {
        logic                    we;
        logic [IDX_W-1:0]        addr;
        logic [PAGE_BITS-1:0]    data;
    } ram_wr_t;

endpackage

@@ rtl/core/ipt_page_ram.sv @@
module ipt_page_ram
    import ipt_pkg::*;
(
    input  logic                 clk,
    input  ram_wr_t              wr,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [PAGE_BITS-1:0] rd_data
);

    // page number stored per frame, contents undefined until written
    logic [PAGE_BITS-1:0] mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ipt_scan_ctrl.sv @@
`include "assert_macros.svh"

module ipt_scan_ctrl
    import ipt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output ram_wr_t              ram_wr,
    output logic [IDX_W-1:0]     ram_rd_addr,
    input  logic [PAGE_BITS-1:0] ram_rd_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 occ_q_reg, occ_q_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     found_idx_reg, found_idx_next;
    logic [FRAMES-1:0]    occ_reg;
    logic                 in_range;
    logic                 hit;

    assign in_range = 32'(req.frame) < 32'(FRAMES);
    assign hit      = cmp_valid_reg && occ_q_reg && (ram_rd_data == page_reg);

    assign ram_rd_addr = idx_reg;
    assign res.status      = status_reg;
    assign res.found_frame = FOUND_W'(found_idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = idx_reg;
        occ_q_next      = occ_reg[idx_reg];
        page_next       = page_reg;
        status_next     = status_reg;
        found_idx_next  = found_idx_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        ram_wr.we       = 1'b0;
        ram_wr.addr     = IDX_W'(req.frame);
        ram_wr.data     = req.page;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    page_next       = req.page;
                    found_idx_next  = '0;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    if (req.opcode == OP_INSERT)
                    begin
                        state_next = S_RESP;
                        if (in_range)
                        begin
                            ram_wr.we   = 1'b1;
                            status_next = ST_INSERTED;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    else
                    begin
                        state_next  = S_SCAN;
                        status_next = ST_FAULT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one frame read per cycle, compare its data in the next cycle
                if (!issue_done_reg)
                begin
                    cmp_valid_next = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    status_next    = ST_FOUND;
                    found_idx_next = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_RESP;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            occ_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            if (ram_wr.we)
            begin
                occ_reg[ram_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        occ_q_reg     <= occ_q_next;
        page_reg      <= page_next;
        status_reg    <= status_next;
        found_idx_reg <= found_idx_next;
    end

    `IPT_ASSERT_IMPL(a_found_is_occupied, res_valid && (res.status == ST_FOUND), occ_reg[found_idx_reg], "found frame is not occupied")
    `IPT_ASSERT_IMPL(a_no_write_in_scan, state_reg != S_IDLE, !ram_wr.we, "table written outside idle")
    `IPT_ASSERT_IMPL(a_cmp_only_in_scan, cmp_valid_reg, state_reg == S_SCAN, "compare pending outside scan")

endmodule

@@ rtl/core/inverted_page_table_lookup.sv @@
// inverted page table: one entry per physical frame, lookups scan frames from 0 upward
// insert: request taken in idle, result passes the resp state and then the output register
// lookup: one frame compared per cycle through the page ram read port;
//   a hit ends the scan at that frame, a fault only after frame FRAMES-1 has been compared
// one request in flight; a lookup frees the input once its result leaves the resp state
// async active-low reset clears all occupied marks and the control state, no clearing pass
module inverted_page_table_lookup
    import ipt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode [0], page [20:1], frame [28:21], zero [31:29]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [1:0], found_frame [8:2], zero [15:9]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    req_t                 req;
    res_t                 res;
    logic                 res_valid;
    logic                 res_ready;
    ram_wr_t              ram_wr;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [PAGE_BITS-1:0] ram_rd_data;

    // output register decouples the result from the scan sequencer
    logic                 out_valid_reg;
    res_t                 out_res_reg;

    // unpack the request word
    assign req.opcode = opcode_t'(s_axis_tdata[0]);
    assign req.page   = s_axis_tdata[PAGE_BITS:1];
    assign req.frame  = s_axis_tdata[PAGE_BITS+FRAME_IN_W:PAGE_BITS+1];

    // sequencer may hand over a result when the output slot is free or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    ipt_scan_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req         (req),
        .ram_wr      (ram_wr),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // page numbers per frame, one write and one registered read per cycle
    ipt_page_ram u_ram
    (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - FOUND_W - 2)'(0),
                            out_res_reg.found_frame, out_res_reg.status};

endmodule
